### hdl/pbpc_pkg.sv
// Shared types and constants for the point-between-planes classifier.
// Holds the request/response structs, the sequencer state type and the step codes.
// No dependencies.
`timescale 1ns / 1ps

package pbpc_pkg;

  // fixed widths of the channel fields
  localparam int IN_COORD_W = 16;
  localparam int IDX_W      = 4;
  localparam int SLOT_W     = 2;
  localparam int PAIR_W     = 4;
  localparam int CNT_REG_W  = 5;

  // command codes
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // number of vertices per plane
  localparam logic [SLOT_W-1:0] SLOT_COUNT = 2'd3;

  // coefficient groups of the recompute sequence
  localparam logic [1:0] GRP_A = 2'd0;
  localparam logic [1:0] GRP_B = 2'd1;
  localparam logic [1:0] GRP_C = 2'd2;
  localparam logic [1:0] GRP_D = 2'd3;

  // sub steps inside one D term
  localparam logic [1:0] SUB_T_LOAD = 2'd0;
  localparam logic [1:0] SUB_T_SUB  = 2'd1;
  localparam logic [1:0] SUB_D_ACC  = 2'd2;

  // vertex / product index codes
  localparam logic [1:0] VTX_0 = 2'd0;
  localparam logic [1:0] VTX_1 = 2'd1;
  localparam logic [1:0] VTX_2 = 2'd2;

  typedef struct packed {
    logic                         command;
    logic [IDX_W-1:0]             plane_index;
    logic [SLOT_W-1:0]            vertex_slot;
    logic signed [IN_COORD_W-1:0] coord_x;
    logic signed [IN_COORD_W-1:0] coord_y;
    logic signed [IN_COORD_W-1:0] coord_z;
  } in_req_t;

  typedef struct packed {
    logic              is_good;
    logic [PAIR_W-1:0] pair_index;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VRD,
    ST_RMUL,
    ST_RACC,
    ST_CWR,
    ST_CRD,
    ST_EMUL,
    ST_EACC,
    ST_ECHK,
    ST_DONE
  } seq_state_t;

endpackage

### hdl/point_between_planes_classifier.sv
// Point-between-planes classifier: plane store, coefficient recompute and pair walk.
// Uses one shared signed multiplier under a small sequencer; depends on pbpc_pkg.
// Vertex and coefficient stores are on-chip memories inside this module.
// Load request: three vertex reads, 18 multiply/accumulate steps and one
// coefficient write; loads give no response.
// Classify request: each plane walked takes one coefficient read and three
// passes through the multiplier. One request at a time. After reset a clearing
// pass over every plane address zeroes both stores before the first request is
// taken.
`timescale 1ns / 1ps

module point_between_planes_classifier
  import pbpc_pkg::*;
#(
  parameter int MAX_PLANES = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_REG_W-1:0] cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int P_W   = (MAX_PLANES > 2) ? $clog2(MAX_PLANES) : 1;
  localparam int CNT_W = $clog2(MAX_PLANES + 1);
  localparam int V_W   = 3 * CB;
  localparam int ABC_W = 2 * CB + 3;
  localparam int D_W   = 3 * CB + 4;
  localparam int F_W   = 3 * CB + 6;
  localparam int MA_W  = ABC_W;
  localparam int MB_W  = CB + 1;
  localparam int PR_W  = MA_W + MB_W;
  localparam int C_W   = 3 * ABC_W + D_W;

  seq_state_t state_r, state_nxt;

  // configuration
  logic [CNT_REG_W-1:0] cfg_count_r;

  // memories
  logic [V_W-1:0] vmem0 [MAX_PLANES];
  logic [V_W-1:0] vmem1 [MAX_PLANES];
  logic [V_W-1:0] vmem2 [MAX_PLANES];
  logic [C_W-1:0] cmem  [MAX_PLANES];
  logic [V_W-1:0] vrd0_r, vrd1_r, vrd2_r;
  logic [C_W-1:0] crd_r;

  logic [2:0]     vmem_we;
  logic           cmem_we;
  logic [P_W-1:0] vmem_addr;
  logic [P_W-1:0] cmem_addr;
  logic [V_W-1:0] vmem_wdata;
  logic [C_W-1:0] cmem_wdata;

  // control
  logic [P_W-1:0]   clr_r;
  logic [P_W-1:0]   plane_r;
  logic [P_W-1:0]   p_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] n_lim;
  logic [1:0]       grp_r, j_r, sub_r, estep_r;
  logic [1:0]       j1, j2;

  // datapath
  logic signed [CB-1:0]    in_x, in_y, in_z;
  logic signed [CB-1:0]    px_r, py_r, pz_r;
  logic signed [CB-1:0]    vx [3];
  logic signed [CB-1:0]    vy [3];
  logic signed [CB-1:0]    vz [3];
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PR_W-1:0]  prod_r;
  logic signed [ABC_W-1:0] ca_r, cb_r, cc_r;
  logic signed [D_W-1:0]   cd_r;
  logic signed [MA_W-1:0]  t_r;
  logic signed [F_W-1:0]   f_r, fprev_r;
  logic signed [ABC_W-1:0] rd_a, rd_b, rd_c;
  logic signed [D_W-1:0]   rd_d;

  logic in_acc, ld_ok, rec_done, match, last_plane, out_load;
  logic good_r;
  logic [PAIR_W-1:0] pair_r;
  logic out_valid_r;
  out_rsp_t out_rsp_r;

  assign in_acc = in_valid && !in_stall;
  assign ld_ok  = (in_req.vertex_slot < SLOT_COUNT) &&
                  (32'(in_req.plane_index) < 32'(MAX_PLANES));

  // low coordinate bits, taken as signed
  assign in_x = $signed(in_req.coord_x[CB-1:0]);
  assign in_y = $signed(in_req.coord_y[CB-1:0]);
  assign in_z = $signed(in_req.coord_z[CB-1:0]);

  // plane count clamped to the store depth
  always_comb begin
    if (32'(cfg_count_r) > 32'(MAX_PLANES)) begin
      n_lim = CNT_W'(MAX_PLANES);
    end else begin
      n_lim = CNT_W'(cfg_count_r);
    end
  end

  // vertex read data unpack
  assign vx[0] = $signed(vrd0_r[V_W-1 -: CB]);
  assign vy[0] = $signed(vrd0_r[2*CB-1 -: CB]);
  assign vz[0] = $signed(vrd0_r[CB-1:0]);
  assign vx[1] = $signed(vrd1_r[V_W-1 -: CB]);
  assign vy[1] = $signed(vrd1_r[2*CB-1 -: CB]);
  assign vz[1] = $signed(vrd1_r[CB-1:0]);
  assign vx[2] = $signed(vrd2_r[V_W-1 -: CB]);
  assign vy[2] = $signed(vrd2_r[2*CB-1 -: CB]);
  assign vz[2] = $signed(vrd2_r[CB-1:0]);

  // coefficient read data unpack
  assign rd_a = $signed(crd_r[C_W-1 -: ABC_W]);
  assign rd_b = $signed(crd_r[C_W-ABC_W-1 -: ABC_W]);
  assign rd_c = $signed(crd_r[C_W-2*ABC_W-1 -: ABC_W]);
  assign rd_d = $signed(crd_r[D_W-1:0]);

  // cyclic neighbors of the current vertex
  always_comb begin
    case (j_r)
      VTX_0:   begin j1 = VTX_1; j2 = VTX_2; end
      VTX_1:   begin j1 = VTX_2; j2 = VTX_0; end
      default: begin j1 = VTX_0; j2 = VTX_1; end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_EMUL) begin
      case (estep_r)
        VTX_0:   begin mul_a = rd_a; mul_b = MB_W'(px_r); end
        VTX_1:   begin mul_a = rd_b; mul_b = MB_W'(py_r); end
        default: begin mul_a = rd_c; mul_b = MB_W'(pz_r); end
      endcase
    end else begin
      case (grp_r)
        GRP_A: begin
          mul_a = MA_W'(vy[j_r]);
          mul_b = MB_W'(vz[j1]) - MB_W'(vz[j2]);
        end
        GRP_B: begin
          mul_a = MA_W'(vz[j_r]);
          mul_b = MB_W'(vx[j1]) - MB_W'(vx[j2]);
        end
        GRP_C: begin
          mul_a = MA_W'(vx[j_r]);
          mul_b = MB_W'(vy[j1]) - MB_W'(vy[j2]);
        end
        default: begin
          case (sub_r)
            SUB_T_LOAD: begin mul_a = MA_W'(vy[j1]); mul_b = MB_W'(vz[j2]); end
            SUB_T_SUB:  begin mul_a = MA_W'(vy[j2]); mul_b = MB_W'(vz[j1]); end
            default:    begin mul_a = t_r;           mul_b = MB_W'(vx[j_r]); end
          endcase
        end
      endcase
    end
  end

  assign rec_done   = (grp_r == GRP_D) && (sub_r == SUB_D_ACC) && (j_r == VTX_2);
  assign match      = (p_r != '0) &&
                      ((f_r[F_W-1] && (fprev_r != '0)) ||
                       (!f_r[F_W-1] && (f_r != '0) && fprev_r[F_W-1]));
  assign last_plane = (CNT_W'(p_r) + CNT_W'(1)) == n_r;
  assign out_load   = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == P_W'(MAX_PLANES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.command == CMD_CLASSIFY) begin
            state_nxt = (n_lim < CNT_W'(2)) ? ST_DONE : ST_CRD;
          end else if (ld_ok) begin
            state_nxt = ST_VRD;
          end
        end
      end
      ST_VRD:  state_nxt = ST_RMUL;
      ST_RMUL: state_nxt = ST_RACC;
      ST_RACC: state_nxt = rec_done ? ST_CWR : ST_RMUL;
      ST_CWR:  state_nxt = ST_IDLE;
      ST_CRD:  state_nxt = ST_EMUL;
      ST_EMUL: state_nxt = ST_EACC;
      ST_EACC: state_nxt = (estep_r == VTX_2) ? ST_ECHK : ST_EMUL;
      ST_ECHK: state_nxt = (match || last_plane) ? ST_DONE : ST_CRD;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and memory strobes
  always_comb begin
    in_stall   = 1'b1;
    vmem_we    = '0;
    cmem_we    = 1'b0;
    vmem_addr  = plane_r;
    cmem_addr  = plane_r;
    vmem_wdata = '0;
    cmem_wdata = {ca_r, cb_r, cc_r, cd_r};
    unique case (state_r)
      ST_CLEAR: begin
        vmem_we    = '1;
        cmem_we    = 1'b1;
        vmem_addr  = clr_r;
        cmem_addr  = clr_r;
        cmem_wdata = '0;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        vmem_addr  = P_W'(in_req.plane_index);
        vmem_wdata = {in_x, in_y, in_z};
        if (in_valid && in_req.command == CMD_LOAD && ld_ok) begin
          vmem_we[in_req.vertex_slot] = 1'b1;
        end
      end
      ST_CWR:  cmem_we = 1'b1;
      default: ;
    endcase
  end

  // vertex memories
  always_ff @(posedge clk) begin
    if (vmem_we[0]) vmem0[vmem_addr] <= vmem_wdata;
    if (vmem_we[1]) vmem1[vmem_addr] <= vmem_wdata;
    if (vmem_we[2]) vmem2[vmem_addr] <= vmem_wdata;
    if (state_r == ST_VRD) begin
      vrd0_r <= vmem0[plane_r];
      vrd1_r <= vmem1[plane_r];
      vrd2_r <= vmem2[plane_r];
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cmem_we) cmem[cmem_addr] <= cmem_wdata;
    if (state_r == ST_CRD) crd_r <= cmem[p_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cfg_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + P_W'(1);
      if (cfg_valid && cfg_ready) cfg_count_r <= cfg_data;
      if (state_r == ST_DONE && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        plane_r <= P_W'(in_req.plane_index);
        px_r    <= in_x;
        py_r    <= in_y;
        pz_r    <= in_z;
        n_r     <= n_lim;
        p_r     <= '0;
        good_r  <= 1'b0;
        pair_r  <= '0;
      end
      ST_VRD: begin
        ca_r  <= '0;
        cb_r  <= '0;
        cc_r  <= '0;
        cd_r  <= '0;
        t_r   <= '0;
        grp_r <= GRP_A;
        j_r   <= VTX_0;
        sub_r <= SUB_T_LOAD;
      end
      ST_RACC: begin
        case (grp_r)
          GRP_A: ca_r <= ca_r + ABC_W'(prod_r);
          GRP_B: cb_r <= cb_r + ABC_W'(prod_r);
          GRP_C: cc_r <= cc_r + ABC_W'(prod_r);
          default: begin
            case (sub_r)
              SUB_T_LOAD: t_r  <= MA_W'(prod_r);
              SUB_T_SUB:  t_r  <= t_r - MA_W'(prod_r);
              default:    cd_r <= cd_r - D_W'(prod_r);
            endcase
          end
        endcase
        // step counters
        if (grp_r != GRP_D) begin
          if (j_r == VTX_2) begin
            j_r   <= VTX_0;
            grp_r <= grp_r + 2'd1;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end else if (sub_r == SUB_D_ACC) begin
          sub_r <= SUB_T_LOAD;
          j_r   <= j_r + 2'd1;
        end else begin
          sub_r <= sub_r + 2'd1;
        end
      end
      ST_CRD: estep_r <= VTX_0;
      ST_EMUL: begin
        if (estep_r == VTX_0) f_r <= F_W'(rd_d);
      end
      ST_EACC: begin
        f_r     <= f_r + F_W'(prod_r);
        estep_r <= estep_r + 2'd1;
      end
      ST_ECHK: begin
        fprev_r <= f_r;
        if (match) begin
          good_r <= 1'b1;
          pair_r <= PAIR_W'(p_r);
        end else if (!last_plane) begin
          p_r <= p_r + P_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_rsp_r.is_good    <= good_r;
          out_rsp_r.pair_index <= pair_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign cfg_ready = 1'b1;

endmodule
